/* src/assert_macros.svh */
// Assertion macros used by the filter sequencer.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SVF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define SVF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define SVF_ASSERT(lbl, clk, rst, prop)
`define SVF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/svf_lp_pkg.sv */
// Shared types, constants and tables of the state-variable lowpass.
// No dependencies; used by every module of the block.
package svf_lp_pkg;

   localparam int SAMPLE_BITS_DEF     = 24;
   localparam int TABLE_ADDR_BITS_DEF = 8;

   localparam int K_BITS         = 4;
   localparam int CUT_BITS       = 17;
   localparam int RATE_BITS      = 18;
   localparam int RES_BITS       = 17;
   localparam int CSR_DATA_BITS  = 18;
   localparam int CSR_INDEX_BITS = 1;
   localparam int MUL_BITS       = 34;
   localparam int PROD_BITS      = 2 * MUL_BITS;
   localparam int DIV_N          = 56;
   localparam int DIV_D          = 38;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_SAMPLE_RATE = 1'b0;
   localparam csr_index_type CSR_RESONANCE   = 1'b1;

   localparam logic [RATE_BITS-1:0] RATE_RESET   = 18'd48000;
   localparam logic [CUT_BITS-1:0]  UNIT_Q16     = 17'h10000;
   localparam logic [19:0]          LOG2_1000_Q16 = 20'd653117;
   localparam logic [29:0]          LN2_Q30      = 30'd744261118;
   localparam logic [25:0]          PI_Q24       = 26'd52707179;
   localparam logic [12:0]          BASE_HZ_Q8   = 13'd5120;
   localparam logic [30:0]          ONE_Q30      = 31'h4000_0000;
   localparam logic [30:0]          ONE_Q24      = 31'h0100_0000;
   localparam logic [30:0]          RATIO_MAX    = 31'd2104533975;
   localparam logic [30:0]          G_MAX        = 31'h4000_0000;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_EXP, OP_ROOT, OP_LOWM, OP_LOWP, OP_FREQ,
      OP_RDIV, OP_RSTORE, OP_TAN0, OP_TPROD, OP_TDIV, OP_TSTORE,
      OP_KDIV, OP_KSTORE, OP_DEN, OP_A1DIV, OP_A1STORE, OP_A2, OP_A3,
      OP_V1A, OP_V1B, OP_V2A, OP_V2B, OP_UPD
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_EXP, S_ROOT, S_LOWM, S_LOWP, S_FREQ, S_RDIV, S_RWAIT,
      S_RSTORE, S_TAN0, S_TBIT, S_TDIV, S_TWAIT, S_TSTORE, S_KDIV,
      S_KWAIT, S_KSTORE, S_DEN, S_A1DIV, S_A1WAIT, S_A1STORE, S_A2,
      S_A3, S_V1A, S_V1B, S_V2A, S_V2B, S_UPD
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [K_BITS-1:0]  k;
   } cmd_type;

   typedef struct packed {
      logic fr_bit;
      logic r_bit;
      logic div_done;
   } status_type;

   function automatic logic [30:0] root_value(input logic [K_BITS-1:0] k);
      logic [30:0] v;
      case (k)
         4'd1:    v = 31'd1518500250;
         4'd2:    v = 31'd1276901417;
         4'd3:    v = 31'd1170923762;
         4'd4:    v = 31'd1121280434;
         4'd5:    v = 31'd1097253708;
         4'd6:    v = 31'd1085434106;
         4'd7:    v = 31'd1079572136;
         4'd8:    v = 31'd1076653033;
         4'd9:    v = 31'd1075196444;
         4'd10:   v = 31'd1074468887;
         4'd11:   v = 31'd1074105294;
         4'd12:   v = 31'd1073923544;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

   function automatic logic [24:0] tan_value(input logic [K_BITS-1:0] k);
      logic [24:0] v;
      case (k)
         4'd2:    v = 25'd16777216;
         4'd3:    v = 25'd6949350;
         4'd4:    v = 25'd3337196;
         4'd5:    v = 25'd1652412;
         4'd6:    v = 25'd824212;
         4'd7:    v = 25'd411858;
         4'd8:    v = 25'd205898;
         4'd9:    v = 25'd102945;
         4'd10:   v = 25'd51472;
         4'd11:   v = 25'd25736;
         4'd12:   v = 25'd12868;
         default: v = 25'd0;
      endcase
      return v;
   endfunction

endpackage

/* src/svf_lp_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on svf_lp_pkg for its default widths.
module svf_lp_div #(
   parameter int N = svf_lp_pkg::DIV_N,
   parameter int D = svf_lp_pkg::DIV_D
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff, quo_in;
   logic [D-1:0]  rem_ff, rem_in;
   logic [D-1:0]  dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [D:0]    trial;
   logic [D:0]    diff;
   logic          ge;

   always_comb begin
      trial = {rem_ff, quo_ff[N-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? diff[D-1:0] : trial[D-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* src/svf_lp_dp.sv */
// Datapath: configuration, shared multiplier, divider and filter state.
// Depends on svf_lp_pkg and svf_lp_div; driven by commands from svf_lp_ctrl.
module svf_lp_dp #(
   parameter int SAMPLE_BITS     = svf_lp_pkg::SAMPLE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = svf_lp_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  svf_lp_pkg::cmd_type                  cmd,
   output svf_lp_pkg::status_type               status,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic [svf_lp_pkg::CUT_BITS-1:0]      req_cutoff_norm,
   input  logic                                 req_restart,
   input  logic                                 csr_we,
   input  svf_lp_pkg::csr_index_type            csr_index,
   input  logic [svf_lp_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out
);
   localparam int MB = svf_lp_pkg::MUL_BITS;
   localparam int PB = svf_lp_pkg::PROD_BITS;
   localparam int DN = svf_lp_pkg::DIV_N;
   localparam int DD = svf_lp_pkg::DIV_D;
   localparam logic [15:0] LOW_MASK = 16'((1 << (16 - TABLE_ADDR_BITS)) - 1);
   localparam logic [30:0] R_MASK   = 31'((1 << (32 - TABLE_ADDR_BITS)) - 1);
   localparam logic [62:0] HALF_Q30 = 63'(1) << 29;
   localparam logic [DN-1:0] DIV_2P40 = DN'(1) << 40;
   localparam logic [DN-1:0] DIV_2P54 = DN'(1) << 54;
   localparam logic signed [41:0] Z_MAX = 42'sd2147483647;
   localparam logic signed [41:0] Z_MIN = -42'sd2147483648;
   localparam logic signed [39:0] Y_MAX = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
   localparam logic signed [39:0] Y_MIN = -(40'sd1 <<< (SAMPLE_BITS - 1));

   logic [17:0]                    rate_ff, rate_in;
   logic [16:0]                    res_ff, res_in;
   logic signed [31:0]             z1_ff, z1_in, z2_ff, z2_in;
   logic signed [SAMPLE_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   logic [16:0]                    c_ff, c_in;
   logic [3:0]                     ip_ff, ip_in;
   logic [15:0]                    fr_ff, fr_in;
   logic [30:0]                    p_ff, p_in, m_ff, m_in;
   logic [22:0]                    fq_ff, fq_in;
   logic [30:0]                    r_ff, r_in, t_ff, t_in;
   logic [24:0]                    den_ff, den_in;
   logic [25:0]                    kd_ff, kd_in;
   logic [37:0]                    d_ff, d_in;
   logic [30:0]                    a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic signed [PB-1:0]           acc_ff, acc_in;
   logic signed [39:0]             v1_ff, v1_in, v2_ff, v2_in;

   logic signed [MB-1:0] mul_a, mul_b, v3;
   logic signed [PB-1:0] prod, sum;
   logic [62:0]          rnd;
   logic [52:0]          fsh;
   logic [30:0]          tp;
   logic [16:0]          res_c;
   logic [21:0]          res39;
   logic [20:0]          qd;
   logic signed [41:0]   n1, n2;
   logic                 div_start, div_done;
   logic [DN-1:0]        div_dividend, quo;
   logic [DD-1:0]        div_divisor;
   logic [3:0]           fr_idx;
   logic [4:0]           r_idx;

   svf_lp_div #(.N(DN), .D(DD)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      v3 = MB'(x_ff) - MB'(z2_ff);
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         svf_lp_pkg::OP_EXP: begin
            mul_a = MB'(c_ff);
            mul_b = MB'(svf_lp_pkg::LOG2_1000_Q16);
         end
         svf_lp_pkg::OP_ROOT: begin
            mul_a = MB'(p_ff);
            mul_b = MB'(svf_lp_pkg::root_value(cmd.k));
         end
         svf_lp_pkg::OP_LOWM: begin
            mul_a = MB'(fr_ff & LOW_MASK);
            mul_b = MB'(svf_lp_pkg::LN2_Q30);
         end
         svf_lp_pkg::OP_LOWP: begin
            mul_a = MB'(p_ff);
            mul_b = MB'(m_ff);
         end
         svf_lp_pkg::OP_FREQ: begin
            mul_a = MB'(p_ff);
            mul_b = MB'(svf_lp_pkg::BASE_HZ_Q8);
         end
         svf_lp_pkg::OP_TAN0: begin
            mul_a = MB'(r_ff & R_MASK);
            mul_b = MB'(svf_lp_pkg::PI_Q24);
         end
         svf_lp_pkg::OP_TPROD: begin
            mul_a = MB'(t_ff);
            mul_b = MB'(svf_lp_pkg::tan_value(cmd.k));
         end
         svf_lp_pkg::OP_DEN: begin
            mul_a = MB'(t_ff);
            mul_b = MB'(32'(t_ff) + 32'(kd_ff));
         end
         svf_lp_pkg::OP_A2: begin
            mul_a = MB'(t_ff);
            mul_b = MB'(a1_ff);
         end
         svf_lp_pkg::OP_A3: begin
            mul_a = MB'(t_ff);
            mul_b = MB'(a2_ff);
         end
         svf_lp_pkg::OP_V1A: begin
            mul_a = MB'(a1_ff);
            mul_b = MB'(z1_ff);
         end
         svf_lp_pkg::OP_V1B: begin
            mul_a = MB'(a2_ff);
            mul_b = v3;
         end
         svf_lp_pkg::OP_V2A: begin
            mul_a = MB'(a2_ff);
            mul_b = MB'(z1_ff);
         end
         svf_lp_pkg::OP_V2B: begin
            mul_a = MB'(a3_ff);
            mul_b = v3;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = mul_a * mul_b;
   end

   always_comb begin
      rnd   = 63'(prod) + HALF_Q30;
      fsh   = 53'(prod[43:0]) << ip_ff;
      tp    = prod[54:24];
      sum   = acc_ff + prod;
      res_c = (res_ff > svf_lp_pkg::UNIT_Q16) ? svf_lp_pkg::UNIT_Q16 : res_ff;
      res39 = 22'(res_c) * 22'd39;
      qd    = 21'd32768 + 21'(res39[21:1]);
      n1    = 42'(v1_ff) + 42'(v1_ff) - 42'(z1_ff);
      n2    = 42'(v2_ff) + 42'(v2_ff) - 42'(z2_ff);

      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      rate_in = rate_ff;
      res_in  = res_ff;
      z1_in   = z1_ff;
      z2_in   = z2_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      c_in    = c_ff;
      ip_in   = ip_ff;
      fr_in   = fr_ff;
      p_in    = p_ff;
      m_in    = m_ff;
      fq_in   = fq_ff;
      r_in    = r_ff;
      t_in    = t_ff;
      den_in  = den_ff;
      kd_in   = kd_ff;
      d_in    = d_ff;
      a1_in   = a1_ff;
      a2_in   = a2_ff;
      a3_in   = a3_ff;
      acc_in  = acc_ff;
      v1_in   = v1_ff;
      v2_in   = v2_ff;

      if (csr_we) begin
         unique case (csr_index)
            svf_lp_pkg::CSR_SAMPLE_RATE: rate_in = csr_wdata;
            svf_lp_pkg::CSR_RESONANCE:   res_in  = csr_wdata[16:0];
            default:                     rate_in = rate_ff;
         endcase
      end

      case (cmd.op)
         svf_lp_pkg::OP_LOAD: begin
            x_in = req_sample_in;
            c_in = (req_cutoff_norm > svf_lp_pkg::UNIT_Q16) ?
                   svf_lp_pkg::UNIT_Q16 : req_cutoff_norm;
            if (req_restart) begin
               z1_in = '0;
               z2_in = '0;
            end
         end
         svf_lp_pkg::OP_EXP: begin
            ip_in = prod[35:32];
            fr_in = prod[31:16];
            p_in  = svf_lp_pkg::ONE_Q30;
         end
         svf_lp_pkg::OP_ROOT, svf_lp_pkg::OP_LOWP: p_in = rnd[60:30];
         svf_lp_pkg::OP_LOWM: m_in = svf_lp_pkg::ONE_Q30 + 31'(prod[45:16]);
         svf_lp_pkg::OP_FREQ: fq_in = fsh[52:30];
         svf_lp_pkg::OP_RDIV: begin
            div_start    = 1'b1;
            div_dividend = DN'({fq_ff, 24'b0});
            div_divisor  = DD'(rate_ff);
         end
         svf_lp_pkg::OP_RSTORE: begin
            r_in = (rate_ff == '0 || quo > DN'(svf_lp_pkg::RATIO_MAX)) ?
                   svf_lp_pkg::RATIO_MAX : quo[30:0];
         end
         svf_lp_pkg::OP_TAN0: t_in = prod[62:32];
         svf_lp_pkg::OP_TPROD: begin
            den_in = (tp < svf_lp_pkg::ONE_Q24) ?
                     25'(svf_lp_pkg::ONE_Q24 - tp) : 25'd1;
         end
         svf_lp_pkg::OP_TDIV: begin
            div_start    = 1'b1;
            div_dividend = {32'(t_ff) + 32'(svf_lp_pkg::tan_value(cmd.k)), 24'b0};
            div_divisor  = DD'(den_ff);
         end
         svf_lp_pkg::OP_TSTORE: begin
            t_in = (quo > DN'(svf_lp_pkg::G_MAX)) ? svf_lp_pkg::G_MAX : quo[30:0];
         end
         svf_lp_pkg::OP_KDIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_2P40;
            div_divisor  = DD'(qd);
         end
         svf_lp_pkg::OP_KSTORE: kd_in = quo[25:0];
         svf_lp_pkg::OP_DEN: d_in = 38'(svf_lp_pkg::ONE_Q24) + prod[61:24];
         svf_lp_pkg::OP_A1DIV: begin
            div_start    = 1'b1;
            div_dividend = DIV_2P54;
            div_divisor  = d_ff;
         end
         svf_lp_pkg::OP_A1STORE: a1_in = quo[30:0];
         svf_lp_pkg::OP_A2: a2_in = prod[54:24];
         svf_lp_pkg::OP_A3: a3_in = prod[54:24];
         svf_lp_pkg::OP_V1A, svf_lp_pkg::OP_V2A: acc_in = prod;
         svf_lp_pkg::OP_V1B: v1_in = 40'(sum >>> 30);
         svf_lp_pkg::OP_V2B: v2_in = 40'(z2_ff) + 40'(sum >>> 30);
         svf_lp_pkg::OP_UPD: begin
            z1_in = (n1 > Z_MAX) ? 32'sh7fff_ffff : (n1 < Z_MIN) ? 32'sh8000_0000 : 32'(n1);
            z2_in = (n2 > Z_MAX) ? 32'sh7fff_ffff : (n2 < Z_MIN) ? 32'sh8000_0000 : 32'(n2);
            y_in  = (v2_ff > Y_MAX) ? SAMPLE_BITS'(Y_MAX) :
                    (v2_ff < Y_MIN) ? SAMPLE_BITS'(Y_MIN) : SAMPLE_BITS'(v2_ff);
         end
         default: begin
            y_in = y_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= svf_lp_pkg::RATE_RESET;
         res_ff  <= '0;
         z1_ff   <= '0;
         z2_ff   <= '0;
      end else begin
         rate_ff <= rate_in;
         res_ff  <= res_in;
         z1_ff   <= z1_in;
         z2_ff   <= z2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      c_ff   <= c_in;
      ip_ff  <= ip_in;
      fr_ff  <= fr_in;
      p_ff   <= p_in;
      m_ff   <= m_in;
      fq_ff  <= fq_in;
      r_ff   <= r_in;
      t_ff   <= t_in;
      den_ff <= den_in;
      kd_ff  <= kd_in;
      d_ff   <= d_in;
      a1_ff  <= a1_in;
      a2_ff  <= a2_in;
      a3_ff  <= a3_in;
      acc_ff <= acc_in;
      v1_ff  <= v1_in;
      v2_ff  <= v2_in;
   end

   always_comb begin
      fr_idx = 4'(5'd16 - {1'b0, cmd.k});
      r_idx  = 5'(6'd32 - {2'b0, cmd.k});
      status.fr_bit   = fr_ff[fr_idx];
      status.r_bit    = (r_idx == 5'd31) ? 1'b0 : r_ff[r_idx];
      status.div_done = div_done;
   end

   assign rsp_sample_out = y_ff;
endmodule

/* src/svf_lp_ctrl.sv */
// Sequencer that steps the datapath through one sample's computation.
// Depends on svf_lp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module svf_lp_ctrl #(
   parameter int TABLE_ADDR_BITS = svf_lp_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  svf_lp_pkg::status_type status,
   output svf_lp_pkg::cmd_type    cmd
);
   localparam int KB = svf_lp_pkg::K_BITS;
   localparam logic [KB-1:0] K_TOP   = KB'(TABLE_ADDR_BITS);
   localparam logic [KB-1:0] K_FIRST = KB'(1);
   localparam logic [KB-1:0] K_LAST  = KB'(2);

   svf_lp_pkg::state_type state_ff, state_in;
   logic [KB-1:0]         k_ff, k_in;
   logic                  rsp_pend_ff, rsp_pend_in;
   logic                  out_free;

   assign out_free = !rsp_pend_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      unique case (state_ff)
         svf_lp_pkg::S_IDLE:  if (req_valid) state_in = svf_lp_pkg::S_EXP;
         svf_lp_pkg::S_EXP: begin
            k_in     = K_FIRST;
            state_in = svf_lp_pkg::S_ROOT;
         end
         svf_lp_pkg::S_ROOT: begin
            k_in = k_ff + KB'(1);
            if (k_ff == K_TOP) state_in = svf_lp_pkg::S_LOWM;
         end
         svf_lp_pkg::S_LOWM:   state_in = svf_lp_pkg::S_LOWP;
         svf_lp_pkg::S_LOWP:   state_in = svf_lp_pkg::S_FREQ;
         svf_lp_pkg::S_FREQ:   state_in = svf_lp_pkg::S_RDIV;
         svf_lp_pkg::S_RDIV:   state_in = svf_lp_pkg::S_RWAIT;
         svf_lp_pkg::S_RWAIT:  if (status.div_done) state_in = svf_lp_pkg::S_RSTORE;
         svf_lp_pkg::S_RSTORE: state_in = svf_lp_pkg::S_TAN0;
         svf_lp_pkg::S_TAN0: begin
            k_in     = K_TOP;
            state_in = svf_lp_pkg::S_TBIT;
         end
         svf_lp_pkg::S_TBIT: begin
            if (status.r_bit) begin
               state_in = svf_lp_pkg::S_TDIV;
            end else if (k_ff == K_LAST) begin
               state_in = svf_lp_pkg::S_KDIV;
            end else begin
               k_in = k_ff - KB'(1);
            end
         end
         svf_lp_pkg::S_TDIV:   state_in = svf_lp_pkg::S_TWAIT;
         svf_lp_pkg::S_TWAIT:  if (status.div_done) state_in = svf_lp_pkg::S_TSTORE;
         svf_lp_pkg::S_TSTORE: begin
            if (k_ff == K_LAST) begin
               state_in = svf_lp_pkg::S_KDIV;
            end else begin
               k_in     = k_ff - KB'(1);
               state_in = svf_lp_pkg::S_TBIT;
            end
         end
         svf_lp_pkg::S_KDIV:    state_in = svf_lp_pkg::S_KWAIT;
         svf_lp_pkg::S_KWAIT:   if (status.div_done) state_in = svf_lp_pkg::S_KSTORE;
         svf_lp_pkg::S_KSTORE:  state_in = svf_lp_pkg::S_DEN;
         svf_lp_pkg::S_DEN:     state_in = svf_lp_pkg::S_A1DIV;
         svf_lp_pkg::S_A1DIV:   state_in = svf_lp_pkg::S_A1WAIT;
         svf_lp_pkg::S_A1WAIT:  if (status.div_done) state_in = svf_lp_pkg::S_A1STORE;
         svf_lp_pkg::S_A1STORE: state_in = svf_lp_pkg::S_A2;
         svf_lp_pkg::S_A2:      state_in = svf_lp_pkg::S_A3;
         svf_lp_pkg::S_A3:      state_in = svf_lp_pkg::S_V1A;
         svf_lp_pkg::S_V1A:     state_in = svf_lp_pkg::S_V1B;
         svf_lp_pkg::S_V1B:     state_in = svf_lp_pkg::S_V2A;
         svf_lp_pkg::S_V2A:     state_in = svf_lp_pkg::S_V2B;
         svf_lp_pkg::S_V2B:     state_in = svf_lp_pkg::S_UPD;
         svf_lp_pkg::S_UPD:     if (out_free) state_in = svf_lp_pkg::S_IDLE;
         default:               state_in = svf_lp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.k     = k_ff;
      cmd.op    = svf_lp_pkg::OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         svf_lp_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = svf_lp_pkg::OP_LOAD;
         end
         svf_lp_pkg::S_EXP:     cmd.op = svf_lp_pkg::OP_EXP;
         svf_lp_pkg::S_ROOT:    if (status.fr_bit) cmd.op = svf_lp_pkg::OP_ROOT;
         svf_lp_pkg::S_LOWM:    cmd.op = svf_lp_pkg::OP_LOWM;
         svf_lp_pkg::S_LOWP:    cmd.op = svf_lp_pkg::OP_LOWP;
         svf_lp_pkg::S_FREQ:    cmd.op = svf_lp_pkg::OP_FREQ;
         svf_lp_pkg::S_RDIV:    cmd.op = svf_lp_pkg::OP_RDIV;
         svf_lp_pkg::S_RSTORE:  cmd.op = svf_lp_pkg::OP_RSTORE;
         svf_lp_pkg::S_TAN0:    cmd.op = svf_lp_pkg::OP_TAN0;
         svf_lp_pkg::S_TBIT:    if (status.r_bit) cmd.op = svf_lp_pkg::OP_TPROD;
         svf_lp_pkg::S_TDIV:    cmd.op = svf_lp_pkg::OP_TDIV;
         svf_lp_pkg::S_TSTORE:  cmd.op = svf_lp_pkg::OP_TSTORE;
         svf_lp_pkg::S_KDIV:    cmd.op = svf_lp_pkg::OP_KDIV;
         svf_lp_pkg::S_KSTORE:  cmd.op = svf_lp_pkg::OP_KSTORE;
         svf_lp_pkg::S_DEN:     cmd.op = svf_lp_pkg::OP_DEN;
         svf_lp_pkg::S_A1DIV:   cmd.op = svf_lp_pkg::OP_A1DIV;
         svf_lp_pkg::S_A1STORE: cmd.op = svf_lp_pkg::OP_A1STORE;
         svf_lp_pkg::S_A2:      cmd.op = svf_lp_pkg::OP_A2;
         svf_lp_pkg::S_A3:      cmd.op = svf_lp_pkg::OP_A3;
         svf_lp_pkg::S_V1A:     cmd.op = svf_lp_pkg::OP_V1A;
         svf_lp_pkg::S_V1B:     cmd.op = svf_lp_pkg::OP_V1B;
         svf_lp_pkg::S_V2A:     cmd.op = svf_lp_pkg::OP_V2A;
         svf_lp_pkg::S_V2B:     cmd.op = svf_lp_pkg::OP_V2B;
         svf_lp_pkg::S_UPD:     if (out_free) cmd.op = svf_lp_pkg::OP_UPD;
         default:               cmd.op = svf_lp_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      rsp_pend_in = (cmd.op == svf_lp_pkg::OP_UPD) || (rsp_pend_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= svf_lp_pkg::S_IDLE;
         k_ff        <= '0;
         rsp_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         rsp_pend_ff <= rsp_pend_in;
      end
   end

   assign rsp_valid = rsp_pend_ff;

   `SVF_ASSERT(a_upd_slot_free, clock, reset, (cmd.op == svf_lp_pkg::OP_UPD) |-> out_free)
   `SVF_ASSERT_NEXT(a_load_starts, clock, reset, req_valid && !req_stall, state_ff == svf_lp_pkg::S_EXP)
   `SVF_ASSERT_NEXT(a_upd_shows, clock, reset, cmd.op == svf_lp_pkg::OP_UPD, rsp_valid)
endmodule

/* src/svf_lowpass_with_cutoff_mapping_top.sv */
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_sample_in, req_cutoff_norm, req_restart
// rsp       out        rsp_valid/rsp_stall   rsp_sample_out
// csr       in         csr_we                csr_index, csr_wdata
//
// An item runs three divisions plus one for each set ratio bit in the tangent range;
// each division has its start and store steps around the one-bit-a-cycle divider.
// Reset is synchronous and active high; it clears both integrators and the resonance
// register, returns the sequencer to idle and loads the sample rate with 48000.
// A finished item waits in the output register while the next item is taken; the
// last step of that next item waits until the output register is free.
module svf_lowpass_with_cutoff_mapping_top #(
   parameter int SAMPLE_BITS     = svf_lp_pkg::SAMPLE_BITS_DEF,
   parameter int TABLE_ADDR_BITS = svf_lp_pkg::TABLE_ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   input  logic [svf_lp_pkg::CUT_BITS-1:0]      req_cutoff_norm,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]        rsp_sample_out,
   input  logic                                 csr_we,
   input  svf_lp_pkg::csr_index_type            csr_index,
   input  logic [svf_lp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   svf_lp_pkg::cmd_type    cmd;
   svf_lp_pkg::status_type status;

   svf_lp_dp #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample_in   (req_sample_in),
      .req_cutoff_norm (req_cutoff_norm),
      .req_restart     (req_restart),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_sample_out  (rsp_sample_out)
   );

   svf_lp_ctrl #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );
endmodule

/* bench/tb_top.sv */
// Self-checking bench for the state-variable lowpass: it drives audio items with random
// cutoff and restart flags, sweeps the rate and resonance registers, and checks every output.
// Depends on svf_lp_pkg and svf_lowpass_with_cutoff_mapping_top.
`timescale 1ns / 100ps

class filter_scoreboard;
   localparam longint unsigned UNIT24 = 64'd16777216;
   localparam longint unsigned UNIT30 = 64'd1073741824;
   localparam longint unsigned RATIO_CAP = 64'd2104533975;

   longint unsigned root_tab[9];
   longint unsigned tan_tab[9];
   logic signed [23:0] expected_samples[$];
   longint integ_one;
   longint integ_two;
   longint unsigned rate_hz;
   longint unsigned res_q16;
   int mismatches;
   int checked;

   function new();
      root_tab = '{0, 1518500250, 1276901417, 1170923762, 1121280434, 1097253708,
                   1085434106, 1079572136, 1076653033};
      tan_tab = '{0, 0, 16777216, 6949350, 3337196, 1652412, 824212, 411858, 205898};
      clear();
   endfunction

   function void clear();
      integ_one = 0;
      integ_two = 0;
      rate_hz = 48000;
      res_q16 = 0;
   endfunction

   function void set_register(svf_lp_pkg::csr_index_type idx, logic [17:0] value);
      if (idx == svf_lp_pkg::CSR_SAMPLE_RATE) rate_hz = value;
      else res_q16 = value & 18'h1FFFF;
   endfunction

   function longint unsigned cutoff_hz_q8(longint unsigned c);
      longint unsigned y, ip, fr, p, low;
      if (c > 65536) c = 65536;
      y = (c * 653117) >> 16;
      ip = y >> 16;
      fr = y & 16'hFFFF;
      p = UNIT30;
      for (int k = 1; k <= 8; k++)
         if ((fr >> (16 - k)) & 1) p = (p * root_tab[k] + (UNIT30 >> 1)) >> 30;
      low = fr & 8'hFF;
      p = (p * (UNIT30 + ((low * 744261118) >> 16)) + (UNIT30 >> 1)) >> 30;
      return ((5120 * p) << ip) >> 30;
   endfunction

   function longint unsigned warp_tan(longint unsigned r);
      longint unsigned t, den, prod;
      t = ((r & 24'hFFFFFF) * 52707179) >> 32;
      for (int k = 8; k >= 2; k--) begin
         if ((r >> (32 - k)) & 1) begin
            prod = (t * tan_tab[k]) >> 24;
            den = (prod < UNIT24) ? UNIT24 - prod : 0;
            if (den == 0) den = 1;
            t = ((t + tan_tab[k]) << 24) / den;
            if (t > 64 * UNIT24) t = 64 * UNIT24;
         end
      end
      return t;
   endfunction

   function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function void note_input(logic signed [23:0] sample, logic [16:0] cutoff, logic restart);
      longint unsigned fq, r, g, res, q, kd, d, ua1, ua2;
      longint x, a1, a2, a3, v1, v2, v3;
      x = sample;
      if (restart) begin
         integ_one = 0;
         integ_two = 0;
      end
      fq = cutoff_hz_q8(cutoff);
      r = (rate_hz != 0) ? (fq << 24) / rate_hz : RATIO_CAP;
      if (r > RATIO_CAP) r = RATIO_CAP;
      g = warp_tan(r);
      res = (res_q16 > 65536) ? 65536 : res_q16;
      q = 32768 + ((res * 39) >> 1);
      kd = (64'd1 << 40) / q;
      d = UNIT24 + ((g * (g + kd)) >> 24);
      ua1 = (64'd1 << 54) / d;
      ua2 = (g * ua1) >> 24;
      a1 = ua1;
      a2 = ua2;
      a3 = (g * ua2) >> 24;
      v3 = x - integ_two;
      v1 = (a1 * integ_one + a2 * v3) >>> 30;
      v2 = integ_two + ((a2 * integ_one + a3 * v3) >>> 30);
      integ_one = clamp(2 * v1 - integ_one, -64'sd2147483648, 64'sd2147483647);
      integ_two = clamp(2 * v2 - integ_two, -64'sd2147483648, 64'sd2147483647);
      expected_samples.push_back(24'(clamp(v2, -64'sd8388608, 64'sd8388607)));
   endfunction

   function void check_output(logic signed [23:0] actual);
      logic signed [23:0] want;
      checked++;
      if (expected_samples.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected output item %0d", actual);
         return;
      end
      want = expected_samples.pop_front();
      if (actual !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("Output %0d: expected %0d, got %0d", checked, want, actual);
      end
   endfunction
endclass

module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_sample_in = '0;
   logic [svf_lp_pkg::CUT_BITS-1:0] req_cutoff_norm = '0;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample_out;
   logic csr_we = 1'b0;
   svf_lp_pkg::csr_index_type csr_index = svf_lp_pkg::CSR_SAMPLE_RATE;
   logic [svf_lp_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   filter_scoreboard lowpass_sb = new();
   bit idling_on = 1'b0;
   bit hold_request = 1'b0;
   int items_sent = 0;
   int restarts_sent = 0;

   svf_lowpass_with_cutoff_mapping_top u_top (.*);

   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("Run timed out with %0d outputs pending.", lowpass_sb.expected_samples.size());
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) lowpass_sb.check_output(rsp_sample_out);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 4000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(logic signed [23:0] sample, logic [16:0] cutoff, logic restart);
      req_valid <= 1'b1;
      req_sample_in <= sample;
      req_cutoff_norm <= cutoff;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      lowpass_sb.note_input(sample, cutoff, restart);
      items_sent++;
      restarts_sent += restart;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 1'b0;
      while (lowpass_sb.expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(svf_lp_pkg::csr_index_type idx, logic [17:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      lowpass_sb.set_register(idx, value);
   endtask

   task automatic send_random(int count);
      logic signed [23:0] s;
      logic [16:0] c;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 5))
            0: s = 24'sh7FFFFF;
            1: s = -24'sh800000;
            2: s = $urandom_range(0, 2047) - 1024;
            default: s = $urandom;
         endcase
         if ($urandom_range(0, 15) == 0) c = $urandom_range(65537, 131071);
         else c = $urandom_range(0, 65536);
         send_item(s, c, $urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      logic [17:0] rates[7];
      logic [17:0] resonances[7];
      rates = '{44100, 192000, 0, 262143, 96000, 48000, 44100};
      resonances = '{65536, 0, 131071, 32768, 65535, 16384, 50000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(24'sh7FFFFF, 17'd0, 1'b1);
      send_item(-24'sh800000, 17'd65536, 1'b0);
      send_item(24'sh7FFFFF, 17'd65537, 1'b0);
      send_item(24'sh000000, 17'd131071, 1'b0);
      send_item(-24'sd1, 17'd32768, 1'b0);
      send_item(24'sh555555, 17'd1, 1'b1);
      send_item(-24'sh2AAAAB, 17'd65535, 1'b0);
      drain();
      csr_write(svf_lp_pkg::CSR_RESONANCE, 18'd131071);
      csr_write(svf_lp_pkg::CSR_SAMPLE_RATE, 18'd44100);
      for (int i = 0; i < 10; i++)
         send_item(i[0] ? -24'sh800000 : 24'sh7FFFFF, 17'd40000, i == 0);
      drain();

      idling_on = 1'b1;
      for (int phase = 0; phase < 7; phase++) begin
         csr_write(svf_lp_pkg::CSR_SAMPLE_RATE, rates[phase]);
         csr_write(svf_lp_pkg::CSR_RESONANCE, resonances[phase]);
         if (phase == 1) begin
            hold_request = 1'b1;
            send_random(12);
         end
         if (phase == 6) idling_on = 1'b0;
         send_random(200);
         drain();
      end

      repeat (700) @(posedge clock);
      $display("Sent %0d items (%0d restarts) over seven rate and resonance settings.",
               items_sent, restarts_sent);
      $display("Checked %0d outputs, %0d mismatches.", lowpass_sb.checked,
               lowpass_sb.mismatches);
      if (lowpass_sb.mismatches == 0 && lowpass_sb.expected_samples.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+src
src/svf_lp_pkg.sv
src/svf_lp_div.sv
src/svf_lp_dp.sv
src/svf_lp_ctrl.sv
src/svf_lowpass_with_cutoff_mapping_top.sv
bench/tb_top.sv
